[hw/rtl/fourth_order_second_derivative_core_assert.svh]
// Assertion macros shared by the derivative core RTL.
`ifndef FOURTH_ORDER_SECOND_DERIVATIVE_CORE_ASSERT_SVH
`define FOURTH_ORDER_SECOND_DERIVATIVE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FOSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FOSD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FOSD_ASSERT(lbl, prop, msg)
`define FOSD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hw/rtl/fosd_pkg.sv]
`timescale 1ns / 1ps

package fosd_pkg;

    localparam int MAX_VARS   = 8;
    localparam int MAX_POINTS = 4096;
    localparam int MAX_GHOSTS = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_NV_W   = 4;
    localparam int CFG_NP_W   = 13;
    localparam int CFG_NG_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_POINTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_POINTS = 2'd2;

    localparam int VAR_IDX_W = 3;
    localparam int PT_IDX_W  = 12;

    typedef struct packed {
        logic                 line_end;
        logic [PT_IDX_W-1:0]  point_idx;
        logic [VAR_IDX_W-1:0] var_idx;
    } t_meta;

endpackage

[hw/rtl/fosd_ram.sv]
`timescale 1ns / 1ps

module fosd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/fosd_front.sv]
`timescale 1ns / 1ps
`include "fourth_order_second_derivative_core_assert.svh"

module fosd_front import fosd_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32,
    localparam int SUM_W = SAMPLE_WIDTH + 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_line_start,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SUM_W-1:0] o_sum,
    output t_meta                   o_meta
);

    localparam int SW        = SAMPLE_WIDTH;
    localparam int ROW_W     = 4 * SW;
    localparam int VC_W      = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int VCMP_W    = ((VC_W > CFG_NV_W) ? VC_W : CFG_NV_W) + 1;
    localparam int POINT_CAP = MAX_POINTS + 2 * MAX_GHOSTS + 2;
    localparam int PC_W      = $clog2(POINT_CAP + 1);
    localparam int PW        = PC_W + 1;
    localparam int NP_EW     = $clog2(MAX_POINTS + 1);
    localparam int NG_EW     = $clog2(MAX_GHOSTS + 1);

    logic [CFG_NV_W-1:0] r_num_vars;
    logic [CFG_NP_W-1:0] r_line_points;
    logic [CFG_NG_W-1:0] r_ghost_points;

    logic [CFG_NV_W-1:0] eff_nv;
    logic [NP_EW-1:0]    eff_np;
    logic [NG_EW-1:0]    eff_ng;

    logic [VC_W-1:0]     r_var_cnt;
    logic [PC_W-1:0]     r_pt_cnt;
    logic [VC_W-1:0]     cur_vc;
    logic [PC_W-1:0]     cur_pc;
    logic [VC_W-1:0]     n_var_cnt;
    logic [PC_W-1:0]     n_pt_cnt;
    logic                last_var;
    logic [PW-1:0]       centre;
    logic [PW-1:0]       idx;
    logic [PW+11:0]      idx_ext;
    logic [VC_W+2:0]     vc_ext;
    logic                produce;
    t_meta               meta;

    logic                accept;
    logic                s1_fire;
    logic                r_s1_valid;
    logic                r_s1_produce;
    logic                r_s1_fwd;
    logic                r_s1_row_ok;
    logic [VC_W-1:0]     r_s1_v;
    logic [SW-1:0]       r_s1_x;
    t_meta               r_s1_meta;
    logic [ROW_W-1:0]    r_fwd_row;
    logic [MAX_VARS-1:0] r_row_valid;

    logic [ROW_W-1:0]    ram_q;
    logic [ROW_W-1:0]    row;
    logic [ROW_W-1:0]    new_row;

    logic signed [SW-1:0]    h0, h1, h2, h3, xs;
    logic signed [SUM_W-1:0] e0, e1, e2, e3, e4;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars     <= 4'd1;
            r_line_points  <= 13'd1;
            r_ghost_points <= 4'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_VARS:     r_num_vars     <= i_cfg_data[CFG_NV_W-1:0];
                CFG_LINE_POINTS:  r_line_points  <= i_cfg_data[CFG_NP_W-1:0];
                CFG_GHOST_POINTS: r_ghost_points <= i_cfg_data[CFG_NG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_num_vars == '0) begin
            eff_nv = CFG_NV_W'(1);
        end else if (32'(r_num_vars) > MAX_VARS) begin
            eff_nv = CFG_NV_W'(MAX_VARS);
        end else begin
            eff_nv = r_num_vars;
        end

        priority if (r_line_points == '0) begin
            eff_np = NP_EW'(1);
        end else if (32'(r_line_points) > MAX_POINTS) begin
            eff_np = NP_EW'(MAX_POINTS);
        end else begin
            eff_np = NP_EW'(r_line_points);
        end

        priority if (32'(r_ghost_points) < 32'd2) begin
            eff_ng = NG_EW'(2);
        end else if (32'(r_ghost_points) > MAX_GHOSTS) begin
            eff_ng = NG_EW'(MAX_GHOSTS);
        end else begin
            eff_ng = NG_EW'(r_ghost_points);
        end
    end

    // position of the incoming sample; a line start restarts both counters
    always_comb begin
        cur_vc   = i_line_start ? '0 : r_var_cnt;
        cur_pc   = i_line_start ? '0 : r_pt_cnt;
        last_var = (VCMP_W'(cur_vc) + VCMP_W'(1)) >= VCMP_W'(eff_nv);
        centre   = PW'(cur_pc) - PW'(2);
        idx      = centre - PW'(eff_ng);
        produce  = (PW'(cur_pc) >= PW'(4)) && (centre >= PW'(eff_ng))
                   && (centre < (PW'(eff_ng) + PW'(eff_np)));
        idx_ext  = {12'd0, idx};
        vc_ext   = {3'd0, cur_vc};

        meta.var_idx   = vc_ext[VAR_IDX_W-1:0];
        meta.point_idx = idx_ext[PT_IDX_W-1:0];
        meta.line_end  = (idx == (PW'(eff_np) - PW'(1))) && last_var;

        if (last_var) begin
            n_var_cnt = '0;
            n_pt_cnt  = (cur_pc < PC_W'(POINT_CAP)) ? cur_pc + PC_W'(1) : cur_pc;
        end else begin
            n_var_cnt = cur_vc + VC_W'(1);
            n_pt_cnt  = cur_pc;
        end
    end

    assign s1_fire = r_s1_valid && (!r_s1_produce || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_cnt   <= '0;
            r_pt_cnt    <= '0;
            r_s1_valid  <= 1'b0;
            r_row_valid <= '0;
        end else begin
            if (accept) begin
                r_var_cnt <= n_var_cnt;
                r_pt_cnt  <= n_pt_cnt;
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_fire) begin
                r_row_valid[r_s1_v] <= 1'b1;
            end
        end
    end

    // stage 1 always leaves when a new sample enters, so a row it writes
    // back in that cycle is forwarded instead of read from the RAM
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x       <= i_sample;
            r_s1_v       <= cur_vc;
            r_s1_meta    <= meta;
            r_s1_produce <= produce;
            r_s1_fwd     <= r_s1_valid && (r_s1_v == cur_vc);
            r_s1_row_ok  <= r_row_valid[cur_vc];
            r_fwd_row    <= new_row;
        end
    end

    fosd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VARS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_v),
        .i_wr_data (new_row),
        .i_rd_en   (accept),
        .i_rd_addr (cur_vc),
        .o_rd_data (ram_q)
    );

    always_comb begin
        priority if (r_s1_fwd) begin
            row = r_fwd_row;
        end else if (r_s1_row_ok) begin
            row = ram_q;
        end else begin
            row = '0;
        end

        h0 = row[SW-1:0];
        h1 = row[2*SW-1:SW];
        h2 = row[3*SW-1:2*SW];
        h3 = row[4*SW-1:3*SW];
        xs = r_s1_x;

        new_row = {r_s1_x, row[4*SW-1:SW]};

        e0 = SUM_W'(h0);
        e1 = SUM_W'(h1);
        e2 = SUM_W'(h2);
        e3 = SUM_W'(h3);
        e4 = SUM_W'(xs);

        o_sum = (e1 <<< 4) + (e3 <<< 4) - (e2 <<< 5) + (e2 <<< 1) - e0 - e4;
    end

    assign o_valid = r_s1_valid && r_s1_produce;
    assign o_meta  = r_s1_meta;

    `FOSD_ASSERT(a_start, accept && i_line_start |=> r_s1_valid && !o_valid, "start gave a result")
    `FOSD_ASSERT(a_s1_hold, r_s1_valid && !s1_fire |=> r_s1_valid && $stable(r_s1_x), "item lost")

endmodule

[hw/rtl/fosd_div12.sv]
`timescale 1ns / 1ps
`include "fourth_order_second_derivative_core_assert.svh"

module fosd_div12 import fosd_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32,
    localparam int SUM_W = SAMPLE_WIDTH + 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SUM_W-1:0] i_sum,
    input  t_meta                   i_meta,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_result,
    output t_meta                   o_meta
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int WW  = SW + 1;
    localparam int K   = 2 * ((WW + 1) / 4);
    localparam int HW  = WW - K;
    localparam int CW  = HW + 1;
    localparam int PRW = 2 * CW + 1;

    // 2^K = 3*R + 1, so w/3 = a*R + (a + b)/3 with w = a*2^K + b
    localparam logic [K-1:0]     DIV3_R  = K'(((64'd1 << K) - 64'd1) / 64'd3);
    localparam logic [CW:0]      DIV3_M  = (CW + 1)'((64'd1 << (CW + 2)) / 64'd3 + 64'd1);
    localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(3) << (SW + 1);
    localparam logic [SW-1:0]    RES_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0]    RES_MIN = {1'b1, {(SW - 1){1'b0}}};

    logic             en2, en3, en4, en_out;

    logic             r2_valid, r2_neg, r2_sat;
    logic [WW-1:0]    r2_w;
    t_meta            r2_meta;

    logic             r3_valid, r3_neg, r3_sat;
    logic [WW-1:0]    r3_prod;
    logic [CW-1:0]    r3_c;
    t_meta            r3_meta;

    logic             r4_valid, r4_neg, r4_sat;
    logic [WW-1:0]    r4_q;
    t_meta            r4_meta;

    logic             r_out_valid;
    logic [SW-1:0]    r_out_sd;
    t_meta            r_out_meta;

    logic             neg;
    logic [SUM_W-1:0] mag6;
    logic [HW-1:0]    a_hi;
    logic [K-1:0]     b_lo;
    logic [PRW-1:0]   cm;
    logic [SW-1:0]    q_lo;
    logic [SW-1:0]    n_out_sd;

    assign en_out  = !r_out_valid || i_ready;
    assign en4     = !r4_valid || en_out;
    assign en3     = !r3_valid || en4;
    assign en2     = !r2_valid || en3;
    assign o_ready = en2;

    always_comb begin
        neg  = i_sum[SUM_W-1];
        // |s| + 6, with -s = ~s + 1
        mag6 = (neg ? ~i_sum : i_sum) + (neg ? SUM_W'(7) : SUM_W'(6));
        a_hi = r2_w[WW-1:K];
        b_lo = r2_w[K-1:0];
        cm   = PRW'(r3_c) * PRW'(DIV3_M);
        q_lo = r4_q[SW-1:0];
        priority if (r4_sat) begin
            n_out_sd = r4_neg ? RES_MIN : RES_MAX;
        end else if (r4_neg) begin
            n_out_sd = ~q_lo + SW'(1);
        end else begin
            n_out_sd = q_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en2) begin
                r2_valid <= i_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (en4) begin
                r4_valid <= r3_valid;
            end
            if (en_out) begin
                r_out_valid <= r4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_neg  <= neg;
            r2_sat  <= mag6 >= SAT_LIM;
            r2_w    <= mag6[WW+1:2];
            r2_meta <= i_meta;
        end
        if (en3) begin
            r3_neg  <= r2_neg;
            r3_sat  <= r2_sat;
            r3_prod <= WW'(a_hi) * WW'(DIV3_R);
            r3_c    <= CW'(a_hi) + CW'(b_lo);
            r3_meta <= r2_meta;
        end
        if (en4) begin
            r4_neg  <= r3_neg;
            r4_sat  <= r3_sat;
            r4_q    <= r3_prod + WW'(cm[PRW-1:CW+2]);
            r4_meta <= r3_meta;
        end
        if (en_out) begin
            r_out_sd   <= n_out_sd;
            r_out_meta <= r4_meta;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_sd;
    assign o_meta   = r_out_meta;

    `FOSD_ASSERT(a_quot_range, (r4_valid && !r4_sat) |-> (r4_q[WW-1:SW-1] == '0), "unsaturated quotient out of range")
    `FOSD_ASSERT_RST(a_out_reset, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule

[hw/rtl/fourth_order_second_derivative_core.sv]
`timescale 1ns / 1ps

// Five-point fourth-order second derivative over streamed grid lines. Send
// each line with its ghost points, variables interleaved, tuser high on the
// first sample; each interior point gives one result per variable,
// round((-f[i-2] + 16f[i-1] - 30f[i] + 16f[i+1] - f[i+2]) / 12), saturated,
// issued when f[i+2] arrives, with tlast on the last result of the line. The
// core takes one sample every cycle unless the output stalls; a result
// passes through one register for the history RAM read and four in the
// round/divide-by-12 pipeline. The history is a MAX_VARS-row RAM, one
// row read and written per sample with forwarding between back-to-back
// samples of one variable; per-row valid bits stand in for its reset, so
// no clearing pass is needed. The config port is always ready; write
// registers only between lines while the core is idle.
module fourth_order_second_derivative_core import fosd_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32,
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + PT_IDX_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample
    input  logic                   s_axis_tuser,  // line_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // second_derivative, point_index
    output logic [VAR_IDX_W-1:0]   m_axis_tuser,  // variable_index
    output logic                   m_axis_tlast
);

    localparam int SUM_W = SAMPLE_WIDTH + 7;

    logic                    sum_valid;
    logic                    sum_ready;
    logic signed [SUM_W-1:0] sum;
    t_meta                   sum_meta;
    logic [SAMPLE_WIDTH-1:0] result;
    t_meta                   res_meta;

    fosd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_line_start (s_axis_tuser),
        .o_valid      (sum_valid),
        .i_ready      (sum_ready),
        .o_sum        (sum),
        .o_meta       (sum_meta)
    );

    fosd_div12 #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div12 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sum_valid),
        .o_ready  (sum_ready),
        .i_sum    (sum),
        .i_meta   (sum_meta),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result),
        .o_meta   (res_meta)
    );

    assign m_axis_tdata = OUT_TDATA_W'({res_meta.point_idx, result});
    assign m_axis_tuser = res_meta.var_idx;
    assign m_axis_tlast = res_meta.line_end;

endmodule
